>>> sv/iso_date_to_epoch_days_assert.svh
// ----------------------------------------------------------------------------
// iso_date_to_epoch_days_assert.svh
// Assertion macros shared by the ISO date parser modules.
// ----------------------------------------------------------------------------
`ifndef ISO_DATE_TO_EPOCH_DAYS_ASSERT_SVH
`define ISO_DATE_TO_EPOCH_DAYS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IDTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IDTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/idte_pkg.sv
// ----------------------------------------------------------------------------
// idte_pkg
// Types, constants and calendar tables for the ISO date parser.
// ----------------------------------------------------------------------------
`default_nettype none

package idte_pkg;

    // Character positions within "YYYY-MM-DD".
    localparam logic [3:0] POS_YEAR_LO = 4'd2;
    localparam logic [3:0] POS_DASH1   = 4'd4;
    localparam logic [3:0] POS_DASH2   = 4'd7;
    localparam logic [3:0] POS_LAST    = 4'd9;
    localparam logic [3:0] POS_END     = 4'd10;
    localparam logic [3:0] POS_MAX     = 4'd15;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // 365 * 1970 + leap years before 1970 + 1 for the one-based day.
    localparam logic [22:0] EPOCH_OFFSET = 23'd719529;

    localparam int unsigned DAYS_W = 23;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0] epoch_days;
        logic                     valid_res;
    } res_t;

    // One parsed literal: year split into its century and year-of-century
    // digit pairs, month, day, and whether the layout was correct.
    typedef struct packed {
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [6:0] month;
        logic [6:0] day;
        logic       fmt_ok;
    } date_rec_t;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

>>> sv/iso_date_to_epoch_days.sv
// ----------------------------------------------------------------------------
// iso_date_to_epoch_days
// Streaming "YYYY-MM-DD" parser giving signed days since 1970-01-01.
// ----------------------------------------------------------------------------
// The char channel carries one ASCII byte per transfer, with last_char set on
// the final byte of a literal. For each literal one transfer appears on the
// res channel: the day count in the proleptic Gregorian calendar and a flag
// that is set only for a ten-character literal of the right layout naming a
// real date; otherwise the day count is zero.
// Bytes are taken one per cycle while the queue has room. The record of a
// literal passes from the scanner through the queue between the scanner and
// the day counter into the counter's first stage, and from there into the
// output register, which presents the result on the res channel.
// A stalled receiver holds the output register; the counter's first stage
// and the queue of QUEUE_DEPTH records keep filling behind it, and char_ready
// falls only once the queue is full, so the sustained rate is one byte per
// cycle as long as res_ready is high on average once per literal.
// Reset empties the queue and the pipeline and returns the scanner to the
// first character position.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_date_to_epoch_days #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             char_valid,
    output logic                  char_ready,
    input  wire idte_pkg::char_t  char_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output idte_pkg::res_t        res_data
);

    // Records move from the scanner through the queue to the day counter.
    logic                q_push;
    idte_pkg::date_rec_t q_push_data;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                back_ready;
    idte_pkg::date_rec_t q_head;

    idte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .rec_push   (q_push),
        .rec_data   (q_push_data),
        .rec_full   (q_full)
    );

    idte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The counter takes the head record whenever its first stage is free.
    assign q_pop = !q_empty && back_ready;

    idte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (!q_empty),
        .rec_ready (back_ready),
        .rec_data  (q_head),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

>>> sv/idte_front.sv
// ----------------------------------------------------------------------------
// idte_front
// Character scanner: checks the layout and gathers the digit pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module idte_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_ready,
    input  wire idte_pkg::char_t   char_data,
    output logic                   rec_push,
    output idte_pkg::date_rec_t    rec_data,
    input  wire logic              rec_full
);

    logic [3:0] pos_reg;
    logic [6:0] hi_reg, hi_next;
    logic [6:0] lo_reg, lo_next;
    logic [6:0] mon_reg, mon_next;
    logic [6:0] day_reg, day_next;
    logic       err_reg, err_next;
    logic       accept;
    logic       is_digit;
    logic [3:0] digit;

    assign char_ready = !rec_full;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        is_digit = (char_data.char_code >= idte_pkg::CHAR_ZERO) &&
                   (char_data.char_code <= idte_pkg::CHAR_NINE);
        digit    = is_digit ? 4'(char_data.char_code - idte_pkg::CHAR_ZERO) : 4'd0;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        mon_next = mon_reg;
        day_next = day_reg;
        err_next = err_reg;
        if (pos_reg >= idte_pkg::POS_END)
        begin
            err_next = 1'b1;
        end
        else if ((pos_reg == idte_pkg::POS_DASH1) || (pos_reg == idte_pkg::POS_DASH2))
        begin
            if (char_data.char_code != idte_pkg::CHAR_DASH)
            begin
                err_next = 1'b1;
            end
        end
        else if (!is_digit)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg < idte_pkg::POS_YEAR_LO)
        begin
            hi_next = 7'(11'(hi_reg) * 11'd10 + 11'(digit));
        end
        else if (pos_reg < idte_pkg::POS_DASH1)
        begin
            lo_next = 7'(11'(lo_reg) * 11'd10 + 11'(digit));
        end
        else if (pos_reg < idte_pkg::POS_DASH2)
        begin
            mon_next = 7'(11'(mon_reg) * 11'd10 + 11'(digit));
        end
        else
        begin
            day_next = 7'(11'(day_reg) * 11'd10 + 11'(digit));
        end
    end

    // A record leaves on the last character and carries that character's digit.
    assign rec_push         = accept && char_data.last_char;
    assign rec_data.year_hi = hi_next;
    assign rec_data.year_lo = lo_next;
    assign rec_data.month   = mon_next;
    assign rec_data.day     = day_next;
    assign rec_data.fmt_ok  = !err_next && (pos_reg == idte_pkg::POS_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hi_reg  <= '0;
            lo_reg  <= '0;
            mon_reg <= '0;
            day_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (char_data.last_char)
            begin
                pos_reg <= '0;
                hi_reg  <= '0;
                lo_reg  <= '0;
                mon_reg <= '0;
                day_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                if (pos_reg != idte_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
                hi_reg  <= hi_next;
                lo_reg  <= lo_next;
                mon_reg <= mon_next;
                day_reg <= day_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/idte_queue.sv
// ----------------------------------------------------------------------------
// idte_queue
// Small first-in first-out buffer of parsed date records.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iso_date_to_epoch_days_assert.svh"

module idte_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire idte_pkg::date_rec_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      empty,
    output idte_pkg::date_rec_t       head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    idte_pkg::date_rec_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `IDTE_ASSERT_NOW(a_no_push_full, push, !full, "record written into a full queue")
    `IDTE_ASSERT_NOW(a_no_pop_empty, pop, !empty, "record taken from an empty queue")

endmodule

`default_nettype wire

>>> sv/idte_back.sv
// ----------------------------------------------------------------------------
// idte_back
// Two-stage day count: calendar checks and partial sums, then the total.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iso_date_to_epoch_days_assert.svh"

module idte_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rec_valid,
    output logic                      rec_ready,
    input  wire idte_pkg::date_rec_t  rec_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output idte_pkg::res_t            res_data
);

    // Stage one terms. With year = 100*hi + lo the leap count below the year
    // and the year length reduce to sums of these.
    logic [21:0] p1_reg, p1_next;
    logic [15:0] p2_reg, p2_next;
    logic [8:0]  small_reg, small_next;
    logic        ok_reg, ok_next;
    logic        s1_valid_reg;
    logic        out_valid_reg;
    idte_pkg::res_t out_reg;

    logic        lo_nz;
    logic        leap;
    logic        month_ok;
    logic        day_ok;
    logic [3:0]  mon_idx;
    logic [5:0]  mlen;
    logic [22:0] sum;
    logic        out_take;
    logic        s1_move;

    always_comb
    begin
        lo_nz    = (rec_data.year_lo != '0);
        leap     = lo_nz ? (rec_data.year_lo[1:0] == 2'd0) : (rec_data.year_hi[1:0] == 2'd0);
        month_ok = (rec_data.month >= 7'd1) && (rec_data.month <= 7'd12);
        mon_idx  = month_ok ? rec_data.month[3:0] : 4'd0;
        mlen     = 6'(idte_pkg::month_len(mon_idx)) +
                   6'((mon_idx == 4'd2) && leap);
        day_ok   = (rec_data.day != '0) && (rec_data.day <= 7'(mlen));
        ok_next  = rec_data.fmt_ok && month_ok && day_ok;

        p1_next = 22'(rec_data.year_hi) * 22'd36524 + 22'(rec_data.year_hi[6:2]);
        p2_next = 16'(rec_data.year_lo) * 16'd365 +
                  16'((8'(rec_data.year_lo) + 8'd3) >> 2);
        // The last term folds the century leap correction that survives when
        // the year-of-century is zero and the century is not a multiple of four.
        small_next = idte_pkg::days_before_month(mon_idx) +
                     9'((mon_idx > 4'd2) && leap) +
                     9'(rec_data.day) +
                     9'(!lo_nz && (rec_data.year_hi[1:0] != 2'd0));
    end

    assign out_take  = !out_valid_reg || res_ready;
    assign s1_move   = s1_valid_reg && out_take;
    assign rec_ready = !s1_valid_reg || s1_move;
    assign sum       = 23'(p1_reg) + 23'(p2_reg) + 23'(small_reg) - idte_pkg::EPOCH_OFFSET;

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            small_reg <= small_next;
            ok_reg    <= ok_next;
        end
        if (s1_move)
        begin
            out_reg.epoch_days <= ok_reg ? signed'(sum) : '0;
            out_reg.valid_res  <= ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rec_ready)
            begin
                s1_valid_reg <= rec_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    `IDTE_ASSERT_NEXT(a_s1_held, s1_valid_reg && out_valid_reg && !res_ready, s1_valid_reg, "stage one lost while the output was stalled")
    `IDTE_ASSERT_NOW(a_zero_when_bad, res_valid && !res_data.valid_res, res_data.epoch_days == '0, "invalid date carries a non-zero day count")

endmodule

`default_nettype wire

>>> dv/iso_date_to_epoch_days_test.sv
// ----------------------------------------------------------------------------
// iso_date_to_epoch_days_test
// Self-checking bench for the streaming ISO date to epoch day parser.
// ----------------------------------------------------------------------------
// Date literals are broken into character transfers and queued for a driver
// that presents them on the char channel. A monitor watches both channels. It
// runs every accepted character through a bench-side scanner that works out
// the day count and validity of each literal. It then checks every result
// transfer against the oldest outstanding prediction. A short directed set of
// literals covers the calendar extremes and each kind of malformed input. A
// random set then follows, mostly well-formed dates with random content and
// the rest corrupted, truncated, overlong or pure noise. That random set runs
// through phases with no idling, a slow sender, a stalling receiver and both.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_date_to_epoch_days_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD        = 6;
    localparam int RESET_CYCLES       = 5;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_CYCLES       = 10;
    localparam int RANDOM_CHARS       = 500;
    localparam int PHASES             = 4;
    localparam int EPOCH_YEAR         = 1970;
    localparam int LEAPS_BEFORE_EPOCH = 478;

    typedef logic [7:0] lit_t [$];

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            char_valid = 1'b0;
    logic            char_ready;
    idte_pkg::char_t char_data = '0;
    logic            res_valid;
    logic            res_ready = 1'b0;
    idte_pkg::res_t  res_data;

    // Characters waiting for the driver, and the results the scanner has
    // predicted but the block has not yet delivered.
    idte_pkg::char_t chars_to_send [$];
    idte_pkg::res_t  day_counts_due [$];

    // The bench's own copy of the parser state.
    logic [3:0]  scan_pos = '0;
    logic [13:0] year_acc = '0;
    logic [6:0]  month_acc = '0;
    logic [6:0]  day_acc = '0;
    logic        layout_bad = 1'b0;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  chars_queued = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    // High when the char transfer was taken at the most recent rising edge.
    logic char_taken = 1'b0;

    iso_date_to_epoch_days dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------------

    // Proleptic Gregorian rule; year zero is a leap year.
    function automatic bit is_leap(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Length of a month in 1..12; the caller has already ruled out others.
    function automatic int month_length(input int m, input bit leap_year);
        case (m)
            2:            return leap_year ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Days from 1970-01-01 to a valid date. Leap years below y are counted by
    // the rounded-up divisions by 4, 100 and 400, and the days of the earlier
    // months are summed so that the leap day falls out of month_length.
    function automatic int days_from_epoch(input int y, input int m, input int d);
        int  total;
        bit  leap_year;
        leap_year = is_leap(y);
        total = 365 * (y - EPOCH_YEAR) + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
                - LEAPS_BEFORE_EPOCH + d - 1;
        for (int k = 1; k < m; k++)
            total += month_length(k, leap_year);
        return total;
    endfunction

    // ------------------------------------------------------------------------
    // Scanner: consumes one accepted character and returns 1, with the result
    // in r, when the character closes a literal.
    // ------------------------------------------------------------------------
    function automatic bit scan_char(input idte_pkg::char_t c, output idte_pkg::res_t r);
        logic [3:0] p;
        bit         is_digit;
        logic [3:0] digit;
        bit         ok;
        int         days;
        int         year_i;
        int         month_i;
        int         day_i;
        p = scan_pos;
        is_digit = (c.char_code >= idte_pkg::CHAR_ZERO) &&
                   (c.char_code <= idte_pkg::CHAR_NINE);
        // The ASCII digits sit at 0x30..0x39, so the low nibble is the value.
        digit = is_digit ? c.char_code[3:0] : 4'd0;
        r = '0;

        if (p >= idte_pkg::POS_END)
            layout_bad = 1'b1;
        else if (p == idte_pkg::POS_DASH1 || p == idte_pkg::POS_DASH2)
        begin
            if (c.char_code != idte_pkg::CHAR_DASH)
                layout_bad = 1'b1;
        end
        else if (!is_digit)
            layout_bad = 1'b1;
        else if (p < idte_pkg::POS_DASH1)
            year_acc = 14'(int'(year_acc) * 10 + int'(digit));
        else if (p < idte_pkg::POS_DASH2)
            month_acc = 7'(int'(month_acc) * 10 + int'(digit));
        else
            day_acc = 7'(int'(day_acc) * 10 + int'(digit));

        if (!c.last_char)
        begin
            // The position sticks at its ceiling so overlong literals stay bad.
            if (scan_pos != idte_pkg::POS_MAX)
                scan_pos = scan_pos + 4'd1;
            return 1'b0;
        end

        year_i  = int'(year_acc);
        month_i = int'(month_acc);
        day_i   = int'(day_acc);
        ok = !layout_bad && p == idte_pkg::POS_LAST;
        if (ok && (month_i < 1 || month_i > 12))
            ok = 1'b0;
        if (ok && (day_i < 1 || day_i > month_length(month_i, is_leap(year_i))))
            ok = 1'b0;
        days = ok ? days_from_epoch(year_i, month_i, day_i) : 0;
        r.epoch_days = days[idte_pkg::DAYS_W-1:0];
        r.valid_res  = ok;

        scan_pos   = '0;
        year_acc   = '0;
        month_acc  = '0;
        day_acc    = '0;
        layout_bad = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queue one literal, marking its final byte as the last character.
    task automatic send_literal(input lit_t lit);
        idte_pkg::char_t c;
        foreach (lit[i])
        begin
            c.char_code = lit[i];
            c.last_char = (i == lit.size() - 1);
            chars_to_send.push_back(c);
        end
        chars_queued += lit.size();
    endtask

    // Queue a text literal, optionally with one byte overwritten.
    task automatic send_text(input string s, input int bad_pos = -1,
                             input logic [7:0] bad_byte = 8'h00);
        lit_t lit;
        for (int i = 0; i < s.len(); i++)
            lit.push_back(s[i]);
        if (bad_pos >= 0 && bad_pos < lit.size())
            lit[bad_pos] = bad_byte;
        send_literal(lit);
    endtask

    task automatic send_date(input int y, input int m, input int d);
        send_text($sformatf("%04d-%02d-%02d", y, m, d));
    endtask

    // Block until the driver has nothing left and every prediction has been
    // matched by a result transfer.
    task automatic wait_for_drain();
        while (chars_to_send.size() != 0 || char_valid || day_counts_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: new characters go out on the falling edge. A character whose
    // transfer has not yet happened is held unchanged.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            char_valid <= 1'b0;
        else if (!char_valid || char_taken)
        begin
            if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                char_data  <= chars_to_send.pop_front();
                char_valid <= 1'b1;
            end
            else
                char_valid <= 1'b0;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: on every rising edge, check a result transfer first. Its
    // prediction is always older than any character taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        idte_pkg::res_t got;
        idte_pkg::res_t want;
        idte_pkg::res_t fresh;
        if (!rst_n)
            char_taken <= 1'b0;
        else
        begin
            char_taken <= char_valid && char_ready;
            if (res_valid && res_ready)
            begin
                got = res_data;
                if (day_counts_due.size() == 0)
                    note_mismatch($sformatf("unexpected result days=%0d valid=%0b",
                                            got.epoch_days, got.valid_res));
                else
                begin
                    want = day_counts_due.pop_front();
                    if (got.epoch_days !== want.epoch_days)
                        note_mismatch($sformatf("epoch_days got %0d, want %0d",
                                                got.epoch_days, want.epoch_days));
                    if (got.valid_res !== want.valid_res)
                        note_mismatch($sformatf("valid_res got %b, want %b",
                                                got.valid_res, want.valid_res));
                end
            end
            if (char_valid && char_ready)
            begin
                if (scan_char(char_data, fresh))
                    day_counts_due.push_back(fresh);
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int   pick;
        int   y;
        int   m;
        int   d;
        int   len;
        int   target;
        string s;
        lit_t noise;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed literals: the epoch and its neighbour, both ends of the
        // four-digit year range, the leap-year rule at its edges, and the 31st of a 30-day month.
        send_date(1970, 1, 1);
        send_date(1969, 12, 31);
        send_date(0, 1, 1);
        send_date(9999, 12, 31);
        send_date(2000, 2, 29);
        send_date(1900, 2, 29);
        send_date(0, 2, 29);
        send_date(2024, 2, 29);
        send_date(2023, 2, 29);
        send_date(2021, 4, 31);
        // Months and days out of range.
        send_date(2021, 0, 10);
        send_date(2021, 13, 1);
        send_date(2021, 1, 0);
        send_date(2021, 1, 32);
        send_date(2021, 99, 99);
        // Misplaced dashes and non-digits, including the all-zero and all-one
        // bytes.
        send_text("2021/01-01");
        send_text("2021-01/01");
        send_text("20a1-01-01");
        send_text("2021-01-01", 2, 8'h00);
        send_text("2021-01-01", 8, 8'hFF);
        // Wrong lengths: short, one too many, long enough to saturate the
        // position, and single-character literals.
        send_text("2021-01-1");
        send_text("2021-01-011");
        send_text("2021-01-01-2021-01-01");
        send_text("7");
        send_text("-");
        wait_for_drain();

        // Random literals in phases of idling: none, slow sender, stalling
        // receiver, then a little of both.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 8 : 0;
            stall_pct     = (ph == 2) ? 45 : (ph == 3) ? 8 : 0;
            target = chars_queued + RANDOM_CHARS / PHASES;
            while (chars_queued < target)
            begin
                // Mostly in-range fields, with the calendar edges and
                // out-of-range values mixed in.
                pick = $urandom_range(99);
                y = (pick < 10) ? 0 : (pick < 20) ? 9999 :
                    (pick < 30) ? 1900 + 100 * $urandom_range(1) : $urandom_range(9999);
                m = ($urandom_range(99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 99);
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    m = 2;
                    d = $urandom_range(28, 30);
                end
                else if (pick < 35)
                    d = $urandom_range(29, 32);
                else if (pick < 90)
                    d = $urandom_range(1, 31);
                else
                    d = $urandom_range(0, 99);
                s = $sformatf("%04d-%02d-%02d", y, m, d);

                pick = $urandom_range(99);
                if (pick < 70)
                    send_text(s);
                else if (pick < 82)
                    send_text(s, $urandom_range(9), 8'($urandom_range(255)));
                else if (pick < 86)
                    send_text(s.substr(0, $urandom_range(8)));
                else if (pick < 90)
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        s = {s, $sformatf("%0d", $urandom_range(9))};
                    send_text(s);
                end
                else
                begin
                    // Noise: random bytes with a bias towards digits and dashes.
                    noise.delete();
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                    begin
                        pick = $urandom_range(3);
                        noise.push_back(pick == 0 ? idte_pkg::CHAR_DASH :
                                        pick == 1 ? idte_pkg::CHAR_ZERO + 8'($urandom_range(9)) :
                                        8'($urandom_range(255)));
                    end
                    send_literal(noise);
                end
            end
            wait_for_drain();
        end

        // Allow for the result latency so a stray extra transfer is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (day_counts_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", day_counts_due.size()));

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
